>>> rtl/ncdf_pkg.sv
package ncdf_pkg;

  localparam logic [7:0]  DATE_BYTES = 8'd15;
  localparam logic [9:0]  POS_MAX    = 10'd1023;
  localparam logic [7:0]  COUNT_MAX  = 8'd255;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam int          NUM_CFG    = 7;
  localparam int          NUM_COUNTED = 6;

  localparam logic [2:0] CAT_INCOMING = 3'd0;
  localparam logic [2:0] CAT_MISSED   = 3'd1;
  localparam logic [2:0] CAT_SMS      = 3'd2;
  localparam logic [2:0] CAT_EMAIL    = 3'd3;
  localparam logic [2:0] CAT_SOCIAL   = 3'd4;
  localparam logic [2:0] CAT_SCHEDULE = 3'd5;
  localparam logic [2:0] CAT_OTHER    = 3'd6;

  localparam logic [2:0] CFG_INCOMING       = 3'd0;
  localparam logic [2:0] CFG_INCOMING_COUNT = 3'd1;
  localparam logic [2:0] CFG_MISSED         = 3'd2;
  localparam logic [2:0] CFG_SMS            = 3'd3;
  localparam logic [2:0] CFG_EMAIL          = 3'd4;
  localparam logic [2:0] CFG_SOCIAL         = 3'd5;
  localparam logic [2:0] CFG_SCHEDULE       = 3'd6;

  typedef struct packed {
    logic [15:0] msg_crc;
    logic [15:0] stamp_crc;
    logic [2:0]  cat;
    logic        bad;
    logic        enabled;
    logic        check;
  } req_t;

  // CRC-16/CCITT, poly 0x1021, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c[7:0] = c[7:0] ^ b;
    c = c ^ {12'd0, c[7:4]};
    c = c ^ {c[3:0], 12'd0};
    c = c ^ {3'd0, c[7:0], 5'd0};
    return c;
  endfunction

endpackage

>>> rtl/ncdf_front.sv
module ncdf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic [2:0]          category_i,
  input  logic                last_byte_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic                cfg_data_i,
  output logic                push_o,
  output ncdf_pkg::req_t      req_o
);
  import ncdf_pkg::*;

  logic [NUM_CFG-1:0] cfg_q;
  logic [15:0] msg_crc_q, msg_crc_d, stamp_crc_q, stamp_crc_d;
  logic [9:0]  pos_q;
  logic [7:0]  title_q, body_q, dlen_q, title_d, body_d, dlen_d;
  logic [10:0] total_old, dstart, total_new, pos_next;
  logic        upd_msg, upd_date, bad, enabled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;
    end else if (cfg_we_i && ({29'd0, cfg_index_i} < 32'(NUM_CFG))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    title_d = (pos_q == 10'd1) ? data_byte_i : title_q;
    body_d  = (pos_q == 10'd2) ? data_byte_i : body_q;
    dlen_d  = (pos_q == 10'd3) ? data_byte_i : dlen_q;
    total_old = 11'd4 + {3'd0, title_q} + {3'd0, body_q} + {3'd0, dlen_q};
    dstart    = 11'd4 + {3'd0, title_q} + {3'd0, body_q};
    total_new = 11'd4 + {3'd0, title_d} + {3'd0, body_d} + {3'd0, dlen_d};
    pos_next  = {1'b0, pos_q} + 11'd1;
    upd_msg  = (pos_q < 10'd4) || ({1'b0, pos_q} < total_old);
    upd_date = (pos_q >= 10'd4) && ({1'b0, pos_q} >= dstart) &&
               ({1'b0, pos_q} < dstart + {3'd0, DATE_BYTES});
    msg_crc_d   = upd_msg  ? crc_byte(msg_crc_q, data_byte_i)   : msg_crc_q;
    stamp_crc_d = upd_date ? crc_byte(stamp_crc_q, data_byte_i) : stamp_crc_q;
    bad = (pos_q < 10'd3) || (pos_next < total_new) ||
          ((category_i != CAT_INCOMING) && (dlen_d != DATE_BYTES));
    case (category_i)
      CAT_INCOMING: enabled = cfg_q[CFG_INCOMING] && cfg_q[CFG_INCOMING_COUNT];
      CAT_MISSED:   enabled = cfg_q[CFG_MISSED];
      CAT_SMS:      enabled = cfg_q[CFG_SMS];
      CAT_EMAIL:    enabled = cfg_q[CFG_EMAIL];
      CAT_SOCIAL:   enabled = cfg_q[CFG_SOCIAL];
      CAT_SCHEDULE: enabled = cfg_q[CFG_SCHEDULE];
      default:      enabled = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_crc_q   <= CRC_INIT;
      stamp_crc_q <= CRC_INIT;
      pos_q       <= '0;
      title_q     <= '0;
      body_q      <= '0;
      dlen_q      <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        msg_crc_q   <= CRC_INIT;
        stamp_crc_q <= CRC_INIT;
        pos_q       <= '0;
        title_q     <= '0;
        body_q      <= '0;
        dlen_q      <= '0;
      end else begin
        msg_crc_q   <= msg_crc_d;
        stamp_crc_q <= stamp_crc_d;
        if (pos_q < POS_MAX) begin
          pos_q <= pos_q + 10'd1;
        end
        title_q <= title_d;
        body_q  <= body_d;
        dlen_q  <= dlen_d;
      end
    end
  end

  assign push_o          = accept_i && last_byte_i;
  assign req_o.msg_crc   = msg_crc_d;
  assign req_o.stamp_crc = stamp_crc_d;
  assign req_o.cat       = category_i;
  assign req_o.bad       = bad;
  assign req_o.enabled   = enabled;
  assign req_o.check     = !bad && enabled && (category_i != CAT_INCOMING);

endmodule

>>> rtl/ncdf_queue.sv
module ncdf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ncdf_pkg::req_t push_data_i,
  input  logic           pop_i,
  output ncdf_pkg::req_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import ncdf_pkg::*;

  req_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign pop_data_o = slot_q[rd_ptr_q];
  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);

endmodule

>>> rtl/ncdf_back.sv
module ncdf_back #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ncdf_pkg::req_t req_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [15:0]    message_crc_o,
  output logic [15:0]    stamp_crc_o,
  output logic           is_duplicate_o,
  output logic           store_message_o,
  output logic           bad_date_length_o,
  output logic [7:0]     category_count_o
);
  import ncdf_pkg::*;

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST   = AW'(HISTORY_DEPTH - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [31:0]   hist_mem [HISTORY_DEPTH];
  logic [31:0]   rdata_q;
  logic          cmp_valid_q;
  logic [1:0]    state_q, state_d;
  req_t          req_q;
  logic [AW-1:0] idx_q, wp_q;
  logic [FW-1:0] fill_q;
  logic          hit_q;
  logic [7:0]    cnt_q [NUM_COUNTED];
  logic          out_valid_q;
  logic [31:0]   pair;
  logic          dup, store, can_count, finish, rd_en, wr_en;
  logic [7:0]    cnt_cur, cnt_new;

  assign pair      = {req_q.msg_crc, req_q.stamp_crc};
  assign can_count = (req_q.cat < CAT_OTHER);
  assign dup       = req_q.check && (hit_q || ((fill_q != FILL_FULL) && (pair == 32'd0)));
  assign store     = !req_q.bad && req_q.enabled && !dup;
  assign cnt_cur   = can_count ? cnt_q[req_q.cat] : 8'd0;
  assign cnt_new   = (store && can_count && (cnt_cur < COUNT_MAX)) ? cnt_cur + 8'd1 : cnt_cur;
  assign finish    = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);
  assign pop_o     = (state_q == S_IDLE) && !empty_i;
  assign rd_en     = (state_q == S_SEARCH);
  assign wr_en     = finish && req_q.check && !dup;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          state_d = (req_i.check && (fill_q != '0)) ? S_SEARCH : S_FINISH;
        end
      end
      S_SEARCH: begin
        if ((FW'(idx_q) + FW'(1)) == fill_q) begin
          state_d = S_LAST;
        end
      end
      S_LAST: state_d = S_FINISH;
      S_FINISH: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= hist_mem[idx_q];
    end
    if (wr_en) begin
      hist_mem[wp_q] <= pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q <= req_i;
    end
    if (finish) begin
      message_crc_o     <= req_q.check ? req_q.msg_crc : 16'd0;
      stamp_crc_o       <= req_q.check ? req_q.stamp_crc : 16'd0;
      is_duplicate_o    <= dup;
      store_message_o   <= store;
      bad_date_length_o <= req_q.bad;
      category_count_o  <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      hit_q       <= 1'b0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_COUNTED; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= rd_en;
      if (pop_o) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (rd_en) begin
          idx_q <= idx_q + AW'(1);
        end
        if (cmp_valid_q && (rdata_q == pair)) begin
          hit_q <= 1'b1;
        end
      end
      if (wr_en) begin
        wp_q <= (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
        if (fill_q != FILL_FULL) begin
          fill_q <= fill_q + FW'(1);
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (can_count) begin
          cnt_q[req_q.cat] <= cnt_new;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/notification_crc_duplicate_filter_unit.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   data_byte_i, category_i, last_byte_i
// out       output     out_valid_o / out_stall_i message_crc_o, stamp_crc_o, is_duplicate_o,
//                                                store_message_o, bad_date_length_o,
//                                                category_count_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Bytes are taken one per cycle while the queue is not full, and input stalls only when
// it is full; a two-entry request queue holds finished messages. A message with a history
// search reads all fill history entries (fill is the number written, up to
// HISTORY_DEPTH) through one memory read port, then a last compare; others skip the search.
// Reset empties the history by a fill count; no clearing pass is needed.
module notification_crc_duplicate_filter_unit #(
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  category_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] message_crc_o,
  output logic [15:0] stamp_crc_o,
  output logic        is_duplicate_o,
  output logic        store_message_o,
  output logic        bad_date_length_o,
  output logic [7:0]  category_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic        cfg_data_i
);
  import ncdf_pkg::*;

  logic accept, push, pop, full, empty;
  req_t push_req, pop_req;

  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  ncdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .category_i  (category_i),
    .last_byte_i (last_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .req_o       (push_req)
  );

  ncdf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_req),
    .pop_i       (pop),
    .pop_data_o  (pop_req),
    .full_o      (full),
    .empty_o     (empty)
  );

  ncdf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .req_i             (pop_req),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .message_crc_o     (message_crc_o),
    .stamp_crc_o       (stamp_crc_o),
    .is_duplicate_o    (is_duplicate_o),
    .store_message_o   (store_message_o),
    .bad_date_length_o (bad_date_length_o),
    .category_count_o  (category_count_o)
  );

endmodule
